// File: hw/rtl/dbl_pkg.sv
// ----------------------------------------------------------------------------
// dbl_pkg: shared types and constants for the depth linearizer
// Field widths, register indexes, reset values and the word carried
// down the division chain.
// ----------------------------------------------------------------------------
`default_nettype none

package dbl_pkg;

    // default depth-buffer code width
    localparam int DEPTH_BITS_DEF = 16;

    // fixed field widths
    localparam int CODE_W    = 16;
    localparam int PLANE_W   = 20;
    localparam int CFG_IDX_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NEAR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAR  = 8'd1;

    // plane values after reset
    localparam logic [PLANE_W-1:0] NEAR_RST = 20'd100;
    localparam logic [PLANE_W-1:0] FAR_RST  = 20'd100000;

    // quotient under construction plus the far-plane override
    typedef struct packed {
        logic               force_far;
        logic [PLANE_W-1:0] quo;
    } t_quo;

endpackage

`default_nettype wire

// File: hw/rtl/dbl_front.sv
// ----------------------------------------------------------------------------
// dbl_front: numerator and denominator set-up
// Three registered stages: plane products, numerator and denominator,
// then the special-case checks that send a word straight to the far plane.
// ----------------------------------------------------------------------------
`default_nettype none

module dbl_front #(
    parameter int DEPTH_BITS = dbl_pkg::DEPTH_BITS_DEF,
    localparam int NW = 2 * dbl_pkg::PLANE_W + DEPTH_BITS,
    localparam int DW = dbl_pkg::PLANE_W + DEPTH_BITS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [dbl_pkg::CODE_W-1:0] i_depth_code,
    input  wire logic                       i_not_finite,
    input  wire logic [dbl_pkg::PLANE_W-1:0] i_near,
    input  wire logic [dbl_pkg::PLANE_W-1:0] i_far,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [NW-1:0]                   o_rem,
    output logic [DW-1:0]                   o_den,
    output dbl_pkg::t_quo                   o_quo
);
    import dbl_pkg::*;

    localparam int XW = (DEPTH_BITS > CODE_W) ? DEPTH_BITS : CODE_W;
    localparam logic [XW-1:0] FULL_X = XW'((64'd1 << DEPTH_BITS) - 64'd1);
    localparam logic [DEPTH_BITS-1:0] FULL = FULL_X[DEPTH_BITS-1:0];
    localparam int PW = 2 * PLANE_W;

    logic                  rdy1, rdy2, rdy3;
    logic [XW-1:0]         code_x;
    logic [DEPTH_BITS-1:0] code_sat;
    logic [DEPTH_BITS-1:0] code_inv;
    logic [PW-1:0]         n_fn;
    logic [DW-1:0]         n_fd, n_nc;
    logic [NW-1:0]         n_num;
    logic [DW:0]           den_sum;
    logic                  n_force;

    logic                  r_v1, r_v2, r_v3;
    logic                  r_bad1, r_bad2;
    logic [PW-1:0]         r_fn;
    logic [DW-1:0]         r_fd, r_nc;
    logic [NW-1:0]         r_num;
    logic [DW-1:0]         r_den2;
    logic [NW-1:0]         r_rem3;
    logic [DW-1:0]         r_den3;
    logic                  r_force3;

    // stage hand-off
    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    // saturate the code at full scale
    assign code_x   = XW'(i_depth_code);
    assign code_sat = (code_x > FULL_X) ? FULL : code_x[DEPTH_BITS-1:0];
    assign code_inv = FULL - code_sat;

    // plane products
    assign n_fn = {{PLANE_W{1'b0}}, i_far} * {{PLANE_W{1'b0}}, i_near};
    assign n_fd = {{DEPTH_BITS{1'b0}}, i_far} * {{PLANE_W{1'b0}}, code_inv};
    assign n_nc = {{DEPTH_BITS{1'b0}}, i_near} * {{PLANE_W{1'b0}}, code_sat};

    // numerator far*near*full by shift and subtract, denominator by add
    assign n_num   = {r_fn, {DEPTH_BITS{1'b0}}} - {{DEPTH_BITS{1'b0}}, r_fn};
    assign den_sum = {1'b0, r_fd} + {1'b0, r_nc};

    // far plane when non-finite, zero denominator or quotient past 20 bits
    assign n_force = r_bad2 || (r_den2 == '0) || (r_num >= {r_den2, {PLANE_W{1'b0}}});

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_valid;
        end
        if (rdy1 && i_valid) begin
            r_bad1 <= i_not_finite;
            r_fn   <= n_fn;
            r_fd   <= n_fd;
            r_nc   <= n_nc;
        end
    end

    // stage 2 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
        if (rdy2 && r_v1) begin
            r_bad2 <= r_bad1;
            r_num  <= n_num;
            r_den2 <= den_sum[DW-1:0];
        end
    end

    // stage 3 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
        if (rdy3 && r_v2) begin
            r_rem3   <= r_num;
            r_den3   <= r_den2;
            r_force3 <= n_force;
        end
    end

    assign o_valid         = r_v3;
    assign o_rem           = r_rem3;
    assign o_den           = r_den3;
    assign o_quo.force_far = r_force3;
    assign o_quo.quo       = '0;

endmodule

`default_nettype wire

// File: hw/rtl/dbl_div_cell.sv
// ----------------------------------------------------------------------------
// dbl_div_cell: one restoring division step
// Tries the shifted denominator against the remainder, keeps the
// difference when it fits and sets one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module dbl_div_cell #(
    parameter int DEPTH_BITS = dbl_pkg::DEPTH_BITS_DEF,
    parameter int SHIFT      = 0,
    localparam int NW = 2 * dbl_pkg::PLANE_W + DEPTH_BITS,
    localparam int DW = dbl_pkg::PLANE_W + DEPTH_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [NW-1:0] i_rem,
    input  wire logic [DW-1:0] i_den,
    input  wire dbl_pkg::t_quo i_quo,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [NW-1:0]      o_rem,
    output logic [DW-1:0]      o_den,
    output dbl_pkg::t_quo      o_quo
);
    import dbl_pkg::*;

    logic          rdy;
    logic [NW-1:0] den_sh;
    logic [NW:0]   trial;
    logic          fits;
    logic [NW-1:0] n_rem;
    t_quo          n_quo;

    logic          r_valid;
    logic [NW-1:0] r_rem;
    logic [DW-1:0] r_den;
    t_quo          r_quo;

    assign rdy     = !r_valid || i_ready;
    assign o_ready = rdy;

    // trial subtraction
    assign den_sh = NW'(i_den) << SHIFT;
    assign trial  = {1'b0, i_rem} - {1'b0, den_sh};
    assign fits   = !trial[NW];
    assign n_rem  = fits ? trial[NW-1:0] : i_rem;

    always_comb begin
        n_quo            = i_quo;
        n_quo.quo[SHIFT] = fits;
    end

    // cell register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (rdy) begin
            r_valid <= i_valid;
        end
        if (rdy && i_valid) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_quo <= n_quo;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_quo   = r_quo;

endmodule

`default_nettype wire

// File: hw/rtl/dbl_back.sv
// ----------------------------------------------------------------------------
// dbl_back: clamp and output register
// Applies the far-plane override, then clamps the quotient to the near
// plane first and the far plane second.
// ----------------------------------------------------------------------------
`default_nettype none

module dbl_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire dbl_pkg::t_quo               i_quo,
    input  wire logic [dbl_pkg::PLANE_W-1:0] i_near,
    input  wire logic [dbl_pkg::PLANE_W-1:0] i_far,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [dbl_pkg::PLANE_W-1:0]      o_metric_depth_mm
);
    import dbl_pkg::*;

    logic               rdy;
    logic [PLANE_W-1:0] n_depth;
    logic               r_valid;
    logic [PLANE_W-1:0] r_depth;

    assign rdy     = !r_valid || i_ready;
    assign o_ready = rdy;

    // override and clamp
    always_comb begin
        if (i_quo.force_far) begin
            n_depth = i_far;
        end else if (i_quo.quo < i_near) begin
            n_depth = i_near;
        end else if (i_quo.quo > i_far) begin
            n_depth = i_far;
        end else begin
            n_depth = i_quo.quo;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (rdy) begin
            r_valid <= i_valid;
        end
        if (rdy && i_valid) begin
            r_depth <= n_depth;
        end
    end

    assign o_valid           = r_valid;
    assign o_metric_depth_mm = r_depth;

endmodule

`default_nettype wire

// File: hw/rtl/depth_buffer_linearize.sv
// ----------------------------------------------------------------------------
// depth_buffer_linearize: perspective depth to metric distance
// Turns one normalized depth-buffer sample per word into a distance in
// millimetres between the near and far planes.
// ----------------------------------------------------------------------------
// Takes one sample per clock while the output is not held back, and returns
// one distance per sample, in order: three set-up stages (plane products,
// numerator and denominator, special-case checks), a chain of 20 division
// cells that each settle one quotient bit, and the clamp with the output
// register. The result is far*near*D / (far*(D-c) + near*c) truncated, with
// D the full-scale code, clamped to near first and then to far. A non-finite
// sample, a zero denominator or a quotient of 2^20 or more gives the far
// plane. Every stage holds its word while the next one is full, so gaps close
// up and the input stays open while a result waits at the output, until
// every stage is full. Plane registers: index 0 near, index 1 far; write
// them only while no word is in flight. The write port is always ready.
`default_nettype none

module depth_buffer_linearize #(
    parameter int DEPTH_BITS = dbl_pkg::DEPTH_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [dbl_pkg::CODE_W-1:0]    i_depth_code,
    input  wire logic                          i_not_finite,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [dbl_pkg::PLANE_W-1:0]        o_metric_depth_mm,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [dbl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [dbl_pkg::PLANE_W-1:0]   i_cfg_data
);
    import dbl_pkg::*;

    localparam int NW = 2 * PLANE_W + DEPTH_BITS;
    localparam int DW = PLANE_W + DEPTH_BITS;

    logic [PLANE_W-1:0] r_near;
    logic [PLANE_W-1:0] r_far;

    logic          w_valid [0:PLANE_W];
    logic          w_ready [0:PLANE_W];
    logic [NW-1:0] w_rem   [0:PLANE_W];
    logic [DW-1:0] w_den   [0:PLANE_W];
    t_quo          w_quo   [0:PLANE_W];

    // plane registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= NEAR_RST;
            r_far  <= FAR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_NEAR: r_near <= i_cfg_data;
                REG_FAR:  r_far  <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // set-up stages
    dbl_front #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_depth_code (i_depth_code),
        .i_not_finite (i_not_finite),
        .i_near       (r_near),
        .i_far        (r_far),
        .o_valid      (w_valid[0]),
        .i_ready      (w_ready[0]),
        .o_rem        (w_rem[0]),
        .o_den        (w_den[0]),
        .o_quo        (w_quo[0])
    );

    // division chain, most significant quotient bit first
    for (genvar j = 0; j < PLANE_W; j++) begin : g_cell
        dbl_div_cell #(
            .DEPTH_BITS (DEPTH_BITS),
            .SHIFT      (PLANE_W - 1 - j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[j]),
            .o_ready (w_ready[j]),
            .i_rem   (w_rem[j]),
            .i_den   (w_den[j]),
            .i_quo   (w_quo[j]),
            .o_valid (w_valid[j+1]),
            .i_ready (w_ready[j+1]),
            .o_rem   (w_rem[j+1]),
            .o_den   (w_den[j+1]),
            .o_quo   (w_quo[j+1])
        );
    end

    // clamp and output
    dbl_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_valid[PLANE_W]),
        .o_ready           (w_ready[PLANE_W]),
        .i_quo             (w_quo[PLANE_W]),
        .i_near            (r_near),
        .i_far             (r_far),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_metric_depth_mm (o_metric_depth_mm)
    );

endmodule

`default_nettype wire
